### sv/min_remove_priority_list_core_macros.svh
// Assertion macros for the min-remove priority list core.
// Used by the RTL files that carry concurrent checks; depends on nothing.
`ifndef MIN_REMOVE_PRIORITY_LIST_CORE_MACROS_SVH
`define MIN_REMOVE_PRIORITY_LIST_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MRPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define MRPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MRPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MRPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/mrpl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes, types and address helper for the min-remove priority list.
// No dependencies; every other file but the macro header takes names from here.
package mrpl_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_step;
        logic shift_start;
        logic shift_step;
        logic rd_head;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic remove_go;
        logic peek_go;
        logic scan_done;
        logic shift_done;
        logic out_free;
    } t_sts;

    // Physical slot of a logical offset from the head, wrapping at DEPTH.
    function automatic t_addr slot_add(t_addr base, t_cnt off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

### sv/mrpl_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, configuration write and result.
// Depends on mrpl_pkg for field widths.
interface mrpl_in_if;
    logic                            valid;
    logic                            ready;
    logic [mrpl_pkg::ACT_W-1:0]      action;
    logic signed [mrpl_pkg::DATA_W-1:0] value;
    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface mrpl_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mrpl_pkg::CAP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

interface mrpl_out_if;
    logic                               valid;
    logic                               ready;
    logic [mrpl_pkg::STAT_W-1:0]        status;
    logic signed [mrpl_pkg::DATA_W-1:0] data;
    logic [mrpl_pkg::COUNT_W-1:0]       count;
    modport source (output valid, status, data, count, input ready);
    modport sink   (input valid, status, data, count, output ready);
endinterface

### sv/min_remove_priority_list_core.sv
`timescale 1ns / 1ps
// Top level of the min-remove priority list: binds the sequencer and datapath
// to the channel interfaces. Depends on mrpl_pkg, mrpl_if, mrpl_ctrl, mrpl_dp.
//
//  channel | dir | beat carries              | accepted when
//  --------+-----+---------------------------+---------------------------
//  i_in    | in  | action, value             | i_in.valid  & i_in.ready
//  i_cfg   | in  | capacity (5 bits)         | i_cfg.valid & i_cfg.ready
//  o_out   | out | status, data, count       | o_out.valid & o_out.ready
//
// One request at a time; the input is ready only while the sequencer idles.
// Insert, peek, no-op and any refused request go from the accept through decode
// straight to the response. Remove of n held entries with m on the shorter side
// of the removed slot: a scan of the n entries through the registered read port
// of the entry memory, then a shift of the m entries that closes the gap (m is
// at most 7 for a full list of 16), then the response.
// Reset is synchronous and active low: empty list, capacity 10, no result
// held, and neither input channel is ready while reset is asserted.
// A result waiting in the output register does not block the next accept;
// the following result holds until that beat is taken, adding the stall.
module min_remove_priority_list_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mrpl_in_if.sink           i_in,
    mrpl_cfg_if.sink          i_cfg,
    mrpl_out_if.source        o_out
);

    mrpl_pkg::t_cmd cmd;
    mrpl_pkg::t_sts sts;
    logic           in_ready;
    logic           out_valid;

    // Capacity writes land in a single register and are taken out of reset.
    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // Sequencer: accept, decode, scan, shift, respond.
    mrpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: entry memory, list pointers and result register.
    mrpl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_in.action),
        .i_value     (i_in.value),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_status    (o_out.status),
        .o_data      (o_out.data),
        .o_count     (o_out.count)
    );

endmodule

### sv/mrpl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the min-remove priority list: steps one request through
// decode, scan, shift and response. Depends on mrpl_pkg.
module mrpl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mrpl_pkg::t_sts i_sts,
    output mrpl_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.remove_go) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.rd_head = i_sts.peek_go;
                    n_state       = S_RESP;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/mrpl_dp.sv
`timescale 1ns / 1ps
// Datapath of the min-remove priority list: entry memory, head and count,
// minimum scan, gap-closing shift and the result register. Depends on mrpl_pkg.
`include "min_remove_priority_list_core_macros.svh"
module mrpl_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mrpl_pkg::t_cmd                     i_cmd,
    output mrpl_pkg::t_sts                     o_sts,
    input  logic [mrpl_pkg::ACT_W-1:0]         i_action,
    input  logic signed [mrpl_pkg::DATA_W-1:0] i_value,
    input  logic                               i_cfg_we,
    input  logic [mrpl_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [mrpl_pkg::STAT_W-1:0]        o_status,
    output logic signed [mrpl_pkg::DATA_W-1:0] o_data,
    output logic [mrpl_pkg::COUNT_W-1:0]       o_count
);

    // entry store, one write and one registered read per cycle
    mrpl_pkg::t_data r_mem [mrpl_pkg::DEPTH];
    mrpl_pkg::t_data r_rd_data;

    logic [mrpl_pkg::ACT_W-1:0]  r_action;
    mrpl_pkg::t_data             r_value;
    logic [mrpl_pkg::CAP_W-1:0]  r_cap;
    mrpl_pkg::t_addr             r_head;
    mrpl_pkg::t_cnt              r_count;
    mrpl_pkg::t_cnt              r_idx;
    logic                        r_cmp_vld;
    mrpl_pkg::t_addr             r_cmp_idx;
    mrpl_pkg::t_data             r_min_val;
    mrpl_pkg::t_addr             r_min_pos;
    logic                        r_front;
    logic                        r_wr_pend;
    mrpl_pkg::t_addr             r_wr_addr;
    logic                        r_out_valid;
    logic [mrpl_pkg::STAT_W-1:0] r_out_status;
    mrpl_pkg::t_data             r_out_data;
    logic [mrpl_pkg::COUNT_W-1:0] r_out_count;

    mrpl_pkg::t_cnt              limit;
    logic                        full;
    logic                        empty;
    logic                        scan_issue;
    logic                        shift_issue;
    mrpl_pkg::t_cnt              src_off;
    mrpl_pkg::t_cnt              after;
    logic                        front_pick;
    logic                        rd_en;
    mrpl_pkg::t_addr             rd_addr;
    logic                        wr_en;
    mrpl_pkg::t_addr             wr_addr;
    mrpl_pkg::t_data             wr_data;
    logic [mrpl_pkg::STAT_W-1:0] n_status;
    mrpl_pkg::t_data             n_data;
    mrpl_pkg::t_cnt              n_count;
    mrpl_pkg::t_addr             n_head;
    logic                        cmp_take;

    always_comb begin
        if (int'(r_cap) > mrpl_pkg::DEPTH) begin
            limit = mrpl_pkg::t_cnt'(mrpl_pkg::DEPTH);
        end else begin
            limit = mrpl_pkg::t_cnt'(r_cap);
        end
    end

    assign full        = (r_count >= limit);
    assign empty       = (r_count == '0);
    assign scan_issue  = (r_idx < r_count);
    assign shift_issue = r_front ? (r_idx != '0)
                                 : ((r_idx + mrpl_pkg::t_cnt'(1)) < r_count);
    assign src_off     = r_front ? (r_idx - mrpl_pkg::t_cnt'(1))
                                 : (r_idx + mrpl_pkg::t_cnt'(1));
    assign after       = r_count - mrpl_pkg::t_cnt'(1) - mrpl_pkg::t_cnt'(r_min_pos);
    assign front_pick  = (mrpl_pkg::t_cnt'(r_min_pos) < after);
    assign cmp_take    = r_cmp_vld && ((r_cmp_idx == '0) || (r_rd_data < r_min_val));

    always_comb begin
        o_sts.remove_go  = (r_action == mrpl_pkg::ACT_REMOVE) && !empty;
        o_sts.peek_go    = (r_action == mrpl_pkg::ACT_PEEK) && !empty;
        o_sts.scan_done  = !scan_issue && !r_cmp_vld;
        o_sts.shift_done = !shift_issue && !r_wr_pend;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // read port select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_head;
        if (i_cmd.rd_head) begin
            rd_en = 1'b1;
        end else if (i_cmd.scan_step && scan_issue) begin
            rd_en   = 1'b1;
            rd_addr = mrpl_pkg::slot_add(r_head, r_idx);
        end else if (i_cmd.shift_step && shift_issue) begin
            rd_en   = 1'b1;
            rd_addr = mrpl_pkg::slot_add(r_head, src_off);
        end
    end

    // result and state update for the finishing request
    always_comb begin
        n_status = mrpl_pkg::STAT_OK;
        n_data   = '0;
        n_count  = r_count;
        n_head   = r_head;
        unique case (r_action)
            mrpl_pkg::ACT_INSERT: begin
                if (full) begin
                    n_status = mrpl_pkg::STAT_FULL;
                end else begin
                    n_count = r_count + mrpl_pkg::t_cnt'(1);
                    if (empty) begin
                        n_head = '0;
                    end
                end
            end
            mrpl_pkg::ACT_REMOVE: begin
                if (empty) begin
                    n_status = mrpl_pkg::STAT_EMPTY;
                end else begin
                    n_data  = r_min_val;
                    n_count = r_count - mrpl_pkg::t_cnt'(1);
                    if (r_front) begin
                        n_head = mrpl_pkg::slot_add(r_head, mrpl_pkg::t_cnt'(1));
                    end
                end
            end
            mrpl_pkg::ACT_PEEK: begin
                if (empty) begin
                    n_status = mrpl_pkg::STAT_EMPTY;
                end else begin
                    n_data = r_rd_data;
                end
            end
            default: begin
                n_status = mrpl_pkg::STAT_OK;
            end
        endcase
    end

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_addr;
        wr_data = r_rd_data;
        if (r_wr_pend) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish && (r_action == mrpl_pkg::ACT_INSERT) && !full) begin
            wr_en   = 1'b1;
            wr_addr = empty ? '0 : mrpl_pkg::slot_add(r_head, r_count);
            wr_data = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= mrpl_pkg::CAP_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_vld <= i_cmd.scan_step && scan_issue;
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step && scan_issue) begin
                r_idx <= r_idx + mrpl_pkg::t_cnt'(1);
            end else if (i_cmd.shift_start) begin
                r_idx <= mrpl_pkg::t_cnt'(r_min_pos);
            end else if (i_cmd.shift_step && shift_issue) begin
                r_idx <= src_off;
            end
            if (i_cmd.shift_start) begin
                r_wr_pend <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_wr_pend <= shift_issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.scan_step && scan_issue) begin
            r_cmp_idx <= r_idx[mrpl_pkg::ADDR_W-1:0];
        end
        if (cmp_take) begin
            r_min_val <= r_rd_data;
            r_min_pos <= r_cmp_idx;
        end
        if (i_cmd.shift_start) begin
            r_front <= front_pick;
        end
        if (i_cmd.shift_step && shift_issue) begin
            r_wr_addr <= mrpl_pkg::slot_add(r_head, r_idx);
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_data   <= n_data;
            r_out_count  <= mrpl_pkg::COUNT_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data      = r_out_data;
    assign o_count     = r_out_count;

    `MRPL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= mrpl_pkg::t_cnt'(mrpl_pkg::DEPTH))
    `MRPL_ASSERT_IMP(a_one_writer, i_clk, i_rst_n, r_wr_pend, !i_cmd.finish)
    `MRPL_ASSERT_IMP(a_min_in_list, i_clk, i_rst_n, i_cmd.shift_start, mrpl_pkg::t_cnt'(r_min_pos) < r_count)
    `MRPL_ASSERT_NXT(a_full_keeps, i_clk, i_rst_n, i_cmd.finish && (r_action == mrpl_pkg::ACT_INSERT) && full, r_count == $past(r_count))

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for min_remove_priority_list_core: random request traffic
// with idle gaps, capacity changes between phases, and an in-bench list model.
// Depends on mrpl_pkg, the channel interfaces in mrpl_if and the core RTL.
module tb;
    import mrpl_pkg::*;

    // Action code the core treats as a no-op; the package names only three.
    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    // Give up after this many cycles with no beat on any channel.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Cycles of a deliberate receiver hold-off, long enough to back up the core.
    localparam int unsigned BACKLOG_HOLD = 300;

    typedef struct {
        logic [ACT_W-1:0] action;
        t_data            value;
    } t_list_req;

    typedef struct {
        logic [STAT_W-1:0]  status;
        t_data              data;
        logic [COUNT_W-1:0] count;
    } t_list_outcome;

    logic i_clk;
    logic i_rst_n;

    mrpl_in_if  in_if ();
    mrpl_cfg_if cfg_if ();
    mrpl_out_if out_if ();

    min_remove_priority_list_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Requests waiting to be driven, and results owed by the core, oldest first.
    t_list_req     request_q[$];
    t_list_outcome outcome_q[$];

    // Model of the list contents in arrival order, plus the capacity register.
    t_data          held_values[$];
    logic [CAP_W-1:0] cap_setting;

    int unsigned fail_cnt;
    int unsigned quiet_cycles;

    // Request driver state.
    t_list_req   cur_req;
    bit          offering;
    int unsigned in_gap;
    bit          in_steady;

    // Result monitor state.
    int unsigned out_stall;
    int unsigned hold_left;
    int unsigned beats_seen;
    int unsigned next_hold_at;
    bit          out_steady;

    always #4 i_clk = ~i_clk;

    // Work out what the core must return for one request and update the model.
    // Removal takes the earliest of the smallest values; the physical shift
    // direction inside the core does not change the logical order kept here.
    function automatic t_list_outcome apply_list_action(t_list_req req);
        t_list_outcome res;
        int unsigned   lim;
        int            pos;
        res.status = STAT_OK;
        res.data   = '0;
        lim = (cap_setting > DEPTH) ? DEPTH : cap_setting;
        case (req.action)
            ACT_INSERT: begin
                if (held_values.size() >= lim) begin
                    res.status = STAT_FULL;
                end else begin
                    held_values.push_back(req.value);
                end
            end
            ACT_REMOVE: begin
                if (held_values.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    pos = 0;
                    for (int k = 1; k < held_values.size(); k++) begin
                        if (held_values[k] < held_values[pos]) begin
                            pos = k;
                        end
                    end
                    res.data = held_values[pos];
                    held_values.delete(pos);
                end
            end
            ACT_PEEK: begin
                if (held_values.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.data = held_values[0];
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(held_values.size());
        return res;
    endfunction

    // Mostly no gap, some short ones, a few long ones; none in a steady stretch.
    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Request driver: predict each accepted beat, then idle or present the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                outcome_q.push_back(apply_list_action(cur_req));
                offering = 1'b0;
                in_gap = pick_gap(in_steady);
                if ($urandom_range(63) == 0) begin
                    in_steady = !in_steady;
                end
            end
            if (!offering) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    offering = 1'b1;
                end
            end
            in_if.valid  <= offering;
            in_if.action <= cur_req.action;
            in_if.value  <= cur_req.value;
        end
    end

    // Result monitor: check each beat against the oldest expectation, then
    // decide whether to take the next one. Now and then hold off for a long
    // stretch while requests are still queued, so the core fills and stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with nothing expected: status %0d data %0d count %0d",
                           out_if.status, out_if.data, out_if.count);
                    fail_cnt++;
                end else begin
                    t_list_outcome exp_res;
                    exp_res = outcome_q.pop_front();
                    if (out_if.status !== exp_res.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_res.status, out_if.status);
                        fail_cnt++;
                    end
                    if (out_if.data !== exp_res.data) begin
                        $error("data mismatch: expected %0d, actual %0d",
                               exp_res.data, out_if.data);
                        fail_cnt++;
                    end
                    if (out_if.count !== exp_res.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               exp_res.count, out_if.count);
                        fail_cnt++;
                    end
                end
                beats_seen++;
                if (beats_seen >= next_hold_at && request_q.size() > 16) begin
                    hold_left = BACKLOG_HOLD;
                    next_hold_at = beats_seen + 600;
                end else begin
                    out_stall = pick_gap(out_steady);
                end
                if ($urandom_range(63) == 0) begin
                    out_steady = !out_steady;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which no channel moves a beat.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no beat on any channel for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Write the capacity register; the model takes the new value on the beat.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= cap;
        do @(posedge i_clk); while (!cfg_if.ready);
        cap_setting = cap;
        cfg_if.valid <= 1'b0;
    endtask

    // Hold until every queued request is in and every owed result is out,
    // then let the core settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || offering || outcome_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic push_req(input logic [ACT_W-1:0] act, input t_data val);
        t_list_req req;
        req.action = act;
        req.value  = val;
        request_q.push_back(req);
    endtask

    // Queue a random phase. Values lean toward small ranges for duplicate
    // minimums and toward the signed extremes, with full-width noise mixed in.
    task automatic queue_random_ops(input int unsigned n, input int unsigned ins_pct);
        int unsigned r;
        logic [ACT_W-1:0] act;
        t_data val;
        @(negedge i_clk);
        for (int unsigned i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < ins_pct) begin
                act = ACT_INSERT;
            end else begin
                r = $urandom_range(99);
                if (r < 70) begin
                    act = ACT_REMOVE;
                end else if (r < 93) begin
                    act = ACT_PEEK;
                end else begin
                    act = ACT_NOP;
                end
            end
            r = $urandom_range(9);
            if (r < 5) begin
                val = $urandom;
            end else if (r < 8) begin
                val = t_data'($urandom_range(15)) - 8;
            end else if (r == 8) begin
                val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end else begin
                val = t_data'($urandom_range(2)) - 1;
            end
            push_req(act, val);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] phase_cap[10];
        int unsigned      phase_ins[10];
        phase_cap = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd16, 5'd2, 5'd12, 5'd31};
        phase_ins = '{60, 50, 50, 65, 55, 40, 45, 50, 60, 30};

        // Drive every input to a known value before the first edge.
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.action = ACT_INSERT;
        in_if.value  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        cap_setting  = CAP_RESET;
        fail_cnt     = 0;
        quiet_cycles = 0;
        offering     = 1'b0;
        in_gap       = 0;
        in_steady    = 1'b0;
        out_stall    = 0;
        hold_left    = 0;
        beats_seen   = 0;
        next_hold_at = 300;
        out_steady   = 1'b0;
        cur_req.action = ACT_INSERT;
        cur_req.value  = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity: empty list, no-op, signed
        // extremes, duplicate minimums taken earliest first, removals from
        // both sides of the list, fill to capacity and a refused insert.
        @(negedge i_clk);
        push_req(ACT_PEEK,   '0);
        push_req(ACT_REMOVE, '0);
        push_req(ACT_NOP,    32'shFFFF_FFFF);
        push_req(ACT_INSERT, 32'sh7FFF_FFFF);
        push_req(ACT_INSERT, 32'sh8000_0000);
        push_req(ACT_INSERT, -1);
        push_req(ACT_INSERT, 0);
        push_req(ACT_INSERT, 1);
        push_req(ACT_INSERT, -1);
        push_req(ACT_INSERT, 32'sh8000_0000);
        push_req(ACT_PEEK,   '0);
        push_req(ACT_REMOVE, '0);
        push_req(ACT_REMOVE, '0);
        push_req(ACT_INSERT, 3);
        push_req(ACT_INSERT, 4);
        push_req(ACT_INSERT, 2);
        push_req(ACT_INSERT, 6);
        push_req(ACT_INSERT, 9);
        push_req(ACT_INSERT, 7);
        push_req(ACT_PEEK,   '0);
        push_req(ACT_NOP,    '0);
        push_req(ACT_REMOVE, '0);
        push_req(ACT_REMOVE, '0);
        push_req(ACT_REMOVE, '0);
        wait_drained();

        // Random phases, each under its own capacity. The list is not emptied
        // between phases, so lowering the capacity leaves entries above it.
        for (int p = 0; p < 10; p++) begin
            write_capacity(phase_cap[p]);
            queue_random_ops(125, phase_ins[p]);
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
